### rtl/core/sorted_list_table_assert.svh
// Assertion macros for the sorted list table.
// Used by the controller and the top level; no other dependencies.
`ifndef SORTED_LIST_TABLE_ASSERT_SVH
`define SORTED_LIST_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define SLT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SLT_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLT_ASSERT(label, clk, rst, prop, msg)
`define SLT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### rtl/core/slt_pkg.sv
// Shared types and codes for the sorted list table.
// No dependencies.
package slt_pkg;
   localparam logic [2:0] OP_APPEND = 3'd0;
   localparam logic [2:0] OP_SORT   = 3'd1;
   localparam logic [2:0] OP_TOGGLE = 3'd2;
   localparam logic [2:0] OP_DEDUP  = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   // datapath commands
   localparam logic [3:0] CMD_NONE    = 4'd0;
   localparam logic [3:0] CMD_LDOP    = 4'd1;  // latch request, i <- index
   localparam logic [3:0] CMD_RD_I    = 4'd2;  // ram read at i
   localparam logic [3:0] CMD_RD_J    = 4'd3;  // ram read at j-1
   localparam logic [3:0] CMD_SET_I   = 4'd4;  // i <- 0, j <- 0 (w)
   localparam logic [3:0] CMD_KEY     = 4'd5;  // key <- rdata, j <- i
   localparam logic [3:0] CMD_SHIFT   = 4'd6;  // mem[j] <- rdata, j--
   localparam logic [3:0] CMD_PUTKEY  = 4'd7;  // mem[j] <- key, i++
   localparam logic [3:0] CMD_COPY    = 4'd8;  // mem[j] <- rdata, j++, i++
   localparam logic [3:0] CMD_INC_I   = 4'd9;
   localparam logic [3:0] CMD_SETCNT  = 4'd10; // count <- j
   localparam logic [3:0] CMD_APPEND  = 4'd11; // mem[count] <- val, count++
   localparam logic [3:0] CMD_INS_BEG = 4'd12; // j <- count
   localparam logic [3:0] CMD_INS_END = 4'd13; // mem[j] <- val, count++
   localparam logic [3:0] CMD_CATCH   = 4'd14; // prev <- rdata, i++
   localparam logic [3:0] CMD_DONE    = 4'd15;

   typedef struct packed {
      logic [3:0] cmd;
   } ctl_type;

   typedef struct packed {
      logic [2:0] func;
      logic       full;     // count reaches depth
      logic       empty;
      logic       i_end;    // i >= count
      logic       j_zero;
      logic       j_at_i;   // j == i
      logic       gt_key;   // rdata > key (signed)
      logic       eq_val;   // rdata == value
      logic       eq_prev;  // rdata == prev
      logic       gt_val;   // rdata > value (signed)
      logic       in_range; // index < count
   } sts_type;
endpackage

### rtl/core/slt_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module slt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write or read one entry
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

### rtl/core/slt_datapath.sv
// Datapath of the sorted list table: table RAM, pointers, count, result.
// Depends on slt_pkg and slt_ram.
module slt_datapath #(
   parameter int DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  slt_pkg::ctl_type       ctl,
   input  logic [2:0]             req_func,
   input  logic signed [31:0]     req_value,
   input  logic [7:0]             req_index,
   output slt_pkg::sts_type       sts,
   output logic [$clog2(DEPTH+1)-1:0] count,
   output logic signed [31:0]     rdata
);
   import slt_pkg::*;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   logic [2:0]        func_ff;
   logic signed [31:0] val_ff, key_ff, prev_ff;
   logic [7:0]        idx_ff;
   logic [CW-1:0]     i_ff, j_ff, cnt_ff;
   logic              we;
   logic [AW-1:0]     addr;
   logic signed [31:0] wdata;
   logic [CW-1:0]     jm1;

   assign jm1 = j_ff - CW'(1);

   // choose ram access per command
   always_comb begin
      we = 1'b0; addr = i_ff[AW-1:0]; wdata = rdata;
      unique case (ctl.cmd)
         CMD_RD_J:    addr = jm1[AW-1:0];
         CMD_SHIFT:   begin we = 1'b1; addr = j_ff[AW-1:0]; end
         CMD_COPY:    begin we = 1'b1; addr = j_ff[AW-1:0]; end
         CMD_PUTKEY:  begin we = 1'b1; addr = j_ff[AW-1:0]; wdata = key_ff; end
         CMD_APPEND:  begin we = 1'b1; addr = cnt_ff[AW-1:0]; wdata = val_ff; end
         CMD_INS_END: begin we = 1'b1; addr = j_ff[AW-1:0]; wdata = val_ff; end
         default: ;
      endcase
   end

   slt_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; i_ff <= '0; j_ff <= '0;
      end else begin
         unique case (ctl.cmd)
            CMD_LDOP: begin
               func_ff <= req_func; val_ff <= req_value; idx_ff <= req_index;
               i_ff <= CW'(req_index);
            end
            CMD_SET_I:   begin i_ff <= '0; j_ff <= '0; end
            CMD_KEY:     begin key_ff <= rdata; j_ff <= i_ff; end
            CMD_SHIFT:   j_ff <= jm1;
            CMD_PUTKEY:  i_ff <= i_ff + CW'(1);
            CMD_COPY: begin
               j_ff <= j_ff + CW'(1); i_ff <= i_ff + CW'(1); prev_ff <= rdata;
            end
            CMD_INC_I:   i_ff <= i_ff + CW'(1);
            CMD_SETCNT:  cnt_ff <= j_ff;
            CMD_APPEND:  cnt_ff <= cnt_ff + CW'(1);
            CMD_INS_BEG: j_ff <= cnt_ff;
            CMD_INS_END: cnt_ff <= cnt_ff + CW'(1);
            CMD_CATCH:   begin prev_ff <= rdata; i_ff <= i_ff + CW'(1); end
            default: ;
         endcase
      end
   end

   // status back to the controller
   always_comb begin
      sts.func     = func_ff;
      sts.full     = (32'(cnt_ff) >= 32'(DEPTH));
      sts.empty    = (cnt_ff == '0);
      sts.i_end    = (i_ff >= cnt_ff);
      sts.j_zero   = (j_ff == '0);
      sts.j_at_i   = (j_ff == i_ff);
      sts.gt_key   = (rdata > key_ff);
      sts.eq_val   = (rdata == val_ff);
      sts.eq_prev  = (rdata == prev_ff);
      sts.gt_val   = (rdata > val_ff);
      sts.in_range = (32'(idx_ff) < 32'(cnt_ff)) && (32'(idx_ff) < 32'(DEPTH));
   end

   assign count = cnt_ff;
endmodule

### rtl/core/slt_ctrl.sv
// Controller of the sorted list table: sequences table walks.
// Depends on slt_pkg and sorted_list_table_assert.svh.
`include "sorted_list_table_assert.svh"
module slt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  slt_pkg::sts_type sts,
   output slt_pkg::ctl_type ctl,
   output logic             rsp_strobe,
   output logic             rsp_found,
   output logic [1:0]       rsp_status,
   output logic             rd_catch
);
   import slt_pkg::*;
   // state codes
   localparam logic [4:0] S_IDLE = 5'd0,  S_DISP = 5'd1,  S_SO_CHK = 5'd2,
                          S_SO_RK = 5'd3, S_SO_KW = 5'd4, S_SO_KEY = 5'd5,
                          S_SO_RJ = 5'd6, S_SO_JW = 5'd7, S_SO_CMP = 5'd8,
                          S_TG_RD = 5'd9, S_TG_W = 5'd10, S_TG_CMP = 5'd11,
                          S_DL_RD = 5'd12, S_DL_W = 5'd13, S_DL_CMP = 5'd14,
                          S_IN_RD = 5'd15, S_IN_W = 5'd16, S_IN_CMP = 5'd17,
                          S_IN_SH = 5'd18, S_IN_SW = 5'd19, S_IN_SP = 5'd20,
                          S_DD_RD = 5'd21, S_DD_W = 5'd22, S_DD_CMP = 5'd23,
                          S_RD_W = 5'd24, S_RD_C = 5'd25, S_RESP = 5'd26,
                          S_DD_GO = 5'd27, S_DD_F = 5'd28, S_DD_FW = 5'd29;

   logic [4:0] state_ff, state_in;
   logic       found_ff, found_in, dedup_ff, dedup_in;
   logic [1:0] stat_ff, stat_in;

   // next state and commands
   always_comb begin
      state_in = state_ff; found_in = found_ff; stat_in = stat_ff;
      dedup_in = dedup_ff; ctl.cmd = CMD_NONE;
      unique case (state_ff)
         S_IDLE: if (start) begin
            ctl.cmd = CMD_LDOP; found_in = 1'b0; stat_in = ST_OK;
            dedup_in = 1'b0; state_in = S_DISP;
         end
         S_DISP: begin
            priority case (sts.func)
               OP_APPEND: begin
                  if (sts.full) stat_in = ST_FULL;
                  else ctl.cmd = CMD_APPEND;
                  state_in = S_RESP;
               end
               OP_SORT: begin ctl.cmd = CMD_SET_I; state_in = S_SO_CHK; end
               OP_TOGGLE: begin ctl.cmd = CMD_SET_I; state_in = S_TG_RD; end
               OP_DEDUP: begin
                  ctl.cmd = CMD_SET_I; dedup_in = 1'b1;
                  state_in = sts.empty ? S_RESP : S_SO_CHK;
               end
               OP_READ: begin
                  if (sts.in_range) state_in = S_RD_W;
                  else begin stat_in = ST_RANGE; state_in = S_RESP; end
               end
               default: state_in = S_RESP;
            endcase
         end
         // insertion sort; i starts at 0 and 0 is trivially placed
         S_SO_CHK: begin
            if (sts.i_end) state_in = dedup_ff ? S_DD_GO : S_RESP;
            else begin ctl.cmd = CMD_RD_I; state_in = S_SO_KW; end
         end
         S_SO_KW:  state_in = S_SO_KEY;
         S_SO_KEY: begin ctl.cmd = CMD_KEY; state_in = S_SO_RJ; end
         S_SO_RJ: begin
            if (sts.j_zero) begin ctl.cmd = CMD_PUTKEY; state_in = S_SO_CHK; end
            else begin ctl.cmd = CMD_RD_J; state_in = S_SO_JW; end
         end
         // hold the read address at j-1 while the data arrives
         S_SO_JW:  begin ctl.cmd = CMD_RD_J; state_in = S_SO_CMP; end
         S_SO_CMP: begin
            if (sts.gt_key) begin ctl.cmd = CMD_SHIFT; state_in = S_SO_RJ; end
            else begin ctl.cmd = CMD_PUTKEY; state_in = S_SO_CHK; end
         end
         S_SO_RK: state_in = S_SO_CHK;
         // toggle: search for the value
         S_TG_RD: begin
            if (sts.i_end) begin
               if (sts.full) begin stat_in = ST_FULL; state_in = S_RESP; end
               else begin ctl.cmd = CMD_SET_I; state_in = S_IN_RD; end
            end else begin ctl.cmd = CMD_RD_I; state_in = S_TG_W; end
         end
         S_TG_W: state_in = S_TG_CMP;
         S_TG_CMP: begin
            if (sts.eq_val) begin
               found_in = 1'b1; ctl.cmd = CMD_SET_I; state_in = S_DL_RD;
            end else begin ctl.cmd = CMD_INC_I; state_in = S_TG_RD; end
         end
         // delete every copy, compacting
         S_DL_RD: begin
            if (sts.i_end) begin ctl.cmd = CMD_SETCNT; state_in = S_RESP; end
            else begin ctl.cmd = CMD_RD_I; state_in = S_DL_W; end
         end
         S_DL_W: state_in = S_DL_CMP;
         S_DL_CMP: begin
            if (!sts.eq_val) ctl.cmd = CMD_COPY;
            else ctl.cmd = CMD_INC_I;
            state_in = S_DL_RD;
         end
         // find the first entry greater than the value; i ends there
         S_IN_RD: begin
            if (sts.i_end) begin ctl.cmd = CMD_INS_BEG; state_in = S_IN_SH; end
            else begin ctl.cmd = CMD_RD_I; state_in = S_IN_W; end
         end
         S_IN_W: state_in = S_IN_CMP;
         S_IN_CMP: begin
            if (sts.gt_val) begin ctl.cmd = CMD_INS_BEG; state_in = S_IN_SH; end
            else begin ctl.cmd = CMD_INC_I; state_in = S_IN_RD; end
         end
         // shift up from the end down to i, then drop the value in at i
         S_IN_SH: begin
            if (sts.j_at_i) begin ctl.cmd = CMD_INS_END; state_in = S_RESP; end
            else begin ctl.cmd = CMD_RD_J; state_in = S_IN_SW; end
         end
         S_IN_SW: begin ctl.cmd = CMD_RD_J; state_in = S_IN_SP; end
         S_IN_SP: begin ctl.cmd = CMD_SHIFT; state_in = S_IN_SH; end
         // dedupe after sort: keep entry 0, then copy differing ones
         S_DD_GO: begin ctl.cmd = CMD_SET_I; state_in = S_DD_F; end
         S_DD_F:  begin ctl.cmd = CMD_RD_I; state_in = S_DD_FW; end
         S_DD_FW: state_in = S_DD_RD;
         S_DD_RD: begin
            // rdata holds entry 0 here: keep it in place
            ctl.cmd = CMD_COPY; state_in = S_DD_CMP;
         end
         S_DD_CMP: begin
            if (sts.i_end) begin ctl.cmd = CMD_SETCNT; state_in = S_RESP; end
            else begin ctl.cmd = CMD_RD_I; state_in = S_DD_W; end
         end
         S_DD_W: begin
            if (sts.eq_prev) ctl.cmd = CMD_INC_I;
            else ctl.cmd = CMD_COPY;
            state_in = S_DD_CMP;
         end
         S_RD_W: state_in = S_RD_C;
         S_RD_C: state_in = S_RESP;
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; found_ff <= 1'b0; stat_ff <= ST_OK; dedup_ff <= 1'b0;
      end else begin
         state_ff <= state_in; found_ff <= found_in;
         stat_ff <= stat_in; dedup_ff <= dedup_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);
   assign rsp_found  = found_ff;
   assign rsp_status = stat_ff;
   assign rd_catch   = (state_ff == S_RD_C);

   `SLT_ASSERT(a_strobe_ends, clock, reset, rsp_strobe |=> !busy, "strobe not followed by idle")
   `SLT_ASSERT(a_start_busy, clock, reset, (start && !busy) |=> busy, "transfer not taken")
   `SLT_ASSERT(a_range_rd, clock, reset, rd_catch |-> stat_ff == ST_OK, "read with bad status")
endmodule

### rtl/core/sorted_list_table.sv
// Sorted list table: a store of signed 32-bit entries with a fill count.
// Each command takes one transfer when start is high and busy low, and
// returns one result on rsp_strobe for a single cycle, which the receiver
// must take then. Toggle walks the table through the single RAM port:
// it searches the entries for the value and then moves entries. Sort is
// insertion sort; dedupe is a sort followed by a compaction. Every walk
// goes through the single-port table RAM.
// Depends on slt_pkg, slt_ctrl, slt_datapath, slt_ram.
`include "sorted_list_table_assert.svh"
module sorted_list_table #(
   parameter int DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_func,
   input  logic signed [31:0] req_value,
   input  logic [7:0]         req_index,
   output logic               rsp_strobe,
   output logic               rsp_found,
   output logic [1:0]         rsp_status,
   output logic [8:0]         rsp_count,
   output logic signed [31:0] rsp_value_out
);
   import slt_pkg::*;
   localparam int CW = $clog2(DEPTH+1);

   ctl_type ctl;
   sts_type sts;
   logic [CW-1:0] count;
   logic rd_catch;
   logic signed [31:0] vout_ff, ram_q;

   slt_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .sts, .ctl, .rsp_strobe, .rsp_found,
      .rsp_status, .rd_catch);

   slt_datapath #(.DEPTH(DEPTH)) u_dp (
      .clock, .reset, .ctl, .req_func, .req_value, .req_index, .sts, .count,
      .rdata(ram_q));

   // capture read value
   always_ff @(posedge clock) begin
      if (reset || (start && !busy)) vout_ff <= '0;
      else if (rd_catch) vout_ff <= ram_q;
   end

   assign rsp_value_out = vout_ff;
   assign rsp_count     = 9'(count);

   `SLT_ASSERT(a_busy_strobe, clock, reset, rsp_strobe |-> busy, "strobe while idle")
   `SLT_ASSERT(a_full, clock, reset, 32'(count) <= 32'(DEPTH), "count over depth")
endmodule
